// ===== rtl/sorted_index_set_unit_assert.svh =====
// ----------------------------------------------------------------------------
// Sorted index set assertion macros
// Concurrent assertion shorthands, compiled out when ASSERT_OFF is defined.
// ----------------------------------------------------------------------------
`ifndef SORTED_INDEX_SET_UNIT_ASSERT_SVH
`define SORTED_INDEX_SET_UNIT_ASSERT_SVH

`ifndef ASSERT_OFF

`define SIS_ASSERT_ALWAYS(lbl, clk, rstn, cond) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (cond)) \
        else $error("sorted index set: invariant violated");

`define SIS_ASSERT_IMPLIES(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("sorted index set: implication violated");

`define SIS_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("sorted index set: next-cycle check violated");

`else

`define SIS_ASSERT_ALWAYS(lbl, clk, rstn, cond)
`define SIS_ASSERT_IMPLIES(lbl, clk, rstn, ante, cons)
`define SIS_ASSERT_NEXT(lbl, clk, rstn, ante, cons)

`endif

`endif

// ===== rtl/sis_pkg.sv =====
// ----------------------------------------------------------------------------
// Sorted index set package
// Beat types, operation codes, cell control and reduction tree sizing.
// ----------------------------------------------------------------------------
package sis_pkg;

    localparam int SIS_CAPACITY = 64;
    localparam int KEY_W        = 31;
    localparam int TREE_RADIX   = 4;

    localparam logic [1:0] KIND_ADD      = 2'd0;
    localparam logic [1:0] KIND_REMOVE   = 2'd1;
    localparam logic [1:0] KIND_CONTAINS = 2'd2;
    localparam logic [1:0] KIND_CLEAR    = 2'd3;

    typedef struct packed {
        logic [1:0]         kind;
        logic signed [31:0] index;
    } t_sis_in;

    typedef struct packed {
        logic             hit;
        logic [6:0]       member_count;
        logic [KEY_W-1:0] largest;
        logic             largest_valid;
        logic             overflow;
    } t_sis_out;

    // Control broadcast to every cell of the row
    typedef struct packed {
        logic apply;
        logic ins;
        logic rem;
        logic clr;
        logic scan;
    } t_cell_ctl;

    // Node count at a given level of the OR tree (level 0 = leaves)
    function automatic int tree_size(input int n, input int lvl);
        int s;
        s = n;
        for (int i = 0; i < lvl; i++) begin
            s = (s + TREE_RADIX - 1) / TREE_RADIX;
        end
        return s;
    endfunction

    function automatic int tree_levels(input int n);
        int s;
        int l;
        s = n;
        l = 0;
        while (s > 1) begin
            s = (s + TREE_RADIX - 1) / TREE_RADIX;
            l++;
        end
        return l;
    endfunction

endpackage

// ===== rtl/sis_cell.sv =====
// ----------------------------------------------------------------------------
// Sorted index set cell
// Holds one member slot; compares against the key and shifts with neighbors.
// ----------------------------------------------------------------------------
module sis_cell (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  sis_pkg::t_cell_ctl       i_ctl,
    input  logic [sis_pkg::KEY_W-1:0] i_key,
    input  logic [sis_pkg::KEY_W-1:0] i_left_value,
    input  logic                     i_left_valid,
    input  logic                     i_left_lt,
    input  logic [sis_pkg::KEY_W-1:0] i_right_value,
    input  logic                     i_right_valid,
    output logic [sis_pkg::KEY_W-1:0] o_value,
    output logic                     o_valid,
    output logic                     o_lt,
    output logic [sis_pkg::KEY_W-1:0] o_word
);
    import sis_pkg::*;

    logic [KEY_W-1:0] r_value;
    logic [KEY_W-1:0] n_value;
    logic             r_valid;
    logic             n_valid;
    logic             w_lt;
    logic             w_eq;

    assign w_lt = r_valid && (r_value < i_key);
    assign w_eq = r_valid && (r_value == i_key);

    // Scan phase: the last valid cell offers its value; search phase: match flag
    always_comb begin
        if (i_ctl.scan) begin
            o_word = (r_valid && !i_right_valid) ? r_value : '0;
        end else begin
            o_word = {{(KEY_W-1){1'b0}}, w_eq};
        end
    end

    always_comb begin
        n_value = r_value;
        n_valid = r_valid;
        if (i_ctl.apply) begin
            if (i_ctl.clr) begin
                n_valid = 1'b0;
            end else if (i_ctl.ins && !w_lt) begin
                // first cell not below the key takes it, the rest shift right
                n_value = i_left_lt ? i_key : i_left_value;
                n_valid = r_valid | i_left_valid;
            end else if (i_ctl.rem && !w_lt) begin
                n_value = i_right_value;
                n_valid = i_right_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
    end

    assign o_value = r_value;
    assign o_valid = r_valid;
    assign o_lt    = w_lt;

endmodule

// ===== rtl/sis_or_tree.sv =====
// ----------------------------------------------------------------------------
// Sorted index set OR tree
// Radix-4 OR reduction over the cell row, registered at every level.
// ----------------------------------------------------------------------------
module sis_or_tree #(
    parameter int N = sis_pkg::SIS_CAPACITY
) (
    input  logic                      i_clk,
    input  logic [sis_pkg::KEY_W-1:0] i_word [N],
    output logic [sis_pkg::KEY_W-1:0] o_word
);
    import sis_pkg::*;

    localparam int LEVELS = tree_levels(N);

    logic [KEY_W-1:0] r_lvl [1:LEVELS][N];

    genvar l, j, k;
    generate
        for (l = 1; l <= LEVELS; l++) begin : g_lvl
            localparam int PREV = tree_size(N, l - 1);
            localparam int CUR  = tree_size(N, l);
            for (j = 0; j < CUR; j++) begin : g_node
                logic [KEY_W-1:0] w_part [TREE_RADIX];
                logic [KEY_W-1:0] w_or;
                for (k = 0; k < TREE_RADIX; k++) begin : g_leg
                    if (TREE_RADIX * j + k < PREV) begin : g_on
                        if (l == 1) begin : g_src_in
                            assign w_part[k] = i_word[TREE_RADIX * j + k];
                        end else begin : g_src_lvl
                            assign w_part[k] = r_lvl[l-1][TREE_RADIX * j + k];
                        end
                    end else begin : g_off
                        assign w_part[k] = '0;
                    end
                end
                always_comb begin
                    w_or = '0;
                    for (int m = 0; m < TREE_RADIX; m++) begin
                        w_or = w_or | w_part[m];
                    end
                end
                always_ff @(posedge i_clk) begin
                    r_lvl[l][j] <= w_or;
                end
            end
        end
    endgenerate

    assign o_word = r_lvl[LEVELS][0];

endmodule

// ===== rtl/sorted_index_set_unit.sv =====
// Flow: each input beat passes through search, update, scan and hand-off states;
//   the OR tree has L = ceil(log4(CAPACITY)) registered levels.
// A new beat is taken only in the idle state, after the previous result is handed
//   off, since each item makes two passes through the registered OR tree that reduces the cell row.
// Reset: synchronous active-low i_rst_n empties the set and idles the control.
// ----------------------------------------------------------------------------
// Sorted index set unit
// Ascending duplicate-free set of row indices kept in a chain of shift cells.
// ----------------------------------------------------------------------------
`include "sorted_index_set_unit_assert.svh"

module sorted_index_set_unit #(
    parameter int CAPACITY = sis_pkg::SIS_CAPACITY
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  sis_pkg::t_sis_in  i_in_data,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output sis_pkg::t_sis_out o_out_data
);
    import sis_pkg::*;

    localparam int LEVELS = tree_levels(CAPACITY);
    localparam int CNT_W  = $clog2(CAPACITY + 1);
    localparam int WAIT_W = $clog2(LEVELS + 1);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_SEARCH = 3'd1;
    localparam logic [2:0] ST_APPLY  = 3'd2;
    localparam logic [2:0] ST_SCAN   = 3'd3;
    localparam logic [2:0] ST_DONE   = 3'd4;

    logic [2:0]       r_state;
    logic [2:0]       n_state;
    logic [WAIT_W-1:0] r_wait;
    logic [WAIT_W-1:0] n_wait;
    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;
    logic [1:0]       r_kind;
    logic [KEY_W-1:0] r_key;
    logic             r_neg;
    logic             r_hit;
    logic             n_hit;
    logic             r_ovf;
    logic             n_ovf;
    logic [KEY_W-1:0] r_largest;
    logic             r_out_valid;
    t_sis_out         r_out;

    t_cell_ctl        w_ctl;
    logic             w_accept;
    logic             w_present;
    logic             w_full;
    logic             w_tree_done;
    logic             w_out_free;
    logic [KEY_W-1:0] w_tree_out;

    logic [KEY_W-1:0] w_value [CAPACITY];
    logic             w_valid [CAPACITY];
    logic             w_lt    [CAPACITY];
    logic [KEY_W-1:0] w_word  [CAPACITY];
    logic [CAPACITY-1:0] w_valid_vec;

    assign o_in_ready  = (r_state == ST_IDLE);
    assign w_accept    = i_in_valid && o_in_ready;
    assign w_present   = w_tree_out[0];
    assign w_full      = (r_count == CNT_W'(CAPACITY));
    assign w_tree_done = (r_wait == WAIT_W'(LEVELS));
    assign w_out_free  = !r_out_valid || i_out_ready;

    // ---- cell row ----
    always_comb begin
        w_ctl       = '0;
        w_ctl.scan  = (r_state == ST_SCAN);
        w_ctl.apply = (r_state == ST_APPLY);
        w_ctl.clr   = (r_kind == KIND_CLEAR);
        w_ctl.ins   = (r_kind == KIND_ADD) && !r_neg && !w_present && !w_full;
        w_ctl.rem   = (r_kind == KIND_REMOVE) && !r_neg && w_present;
    end

    genvar i;
    generate
        for (i = 0; i < CAPACITY; i++) begin : g_cell
            logic [KEY_W-1:0] w_lv;
            logic             w_lvd;
            logic             w_llt;
            logic [KEY_W-1:0] w_rv;
            logic             w_rvd;
            if (i == 0) begin : g_first
                assign w_lv  = '0;
                assign w_lvd = 1'b1;
                assign w_llt = 1'b1;
            end else begin : g_mid_l
                assign w_lv  = w_value[i-1];
                assign w_lvd = w_valid[i-1];
                assign w_llt = w_lt[i-1];
            end
            if (i == CAPACITY - 1) begin : g_last
                assign w_rv  = '0;
                assign w_rvd = 1'b0;
            end else begin : g_mid_r
                assign w_rv  = w_value[i+1];
                assign w_rvd = w_valid[i+1];
            end
            sis_cell u_cell (
                .i_clk         (i_clk),
                .i_rst_n       (i_rst_n),
                .i_ctl         (w_ctl),
                .i_key         (r_key),
                .i_left_value  (w_lv),
                .i_left_valid  (w_lvd),
                .i_left_lt     (w_llt),
                .i_right_value (w_rv),
                .i_right_valid (w_rvd),
                .o_value       (w_value[i]),
                .o_valid       (w_valid[i]),
                .o_lt          (w_lt[i]),
                .o_word        (w_word[i])
            );
            assign w_valid_vec[i] = w_valid[i];
        end
    endgenerate

    sis_or_tree #(
        .N (CAPACITY)
    ) u_tree (
        .i_clk  (i_clk),
        .i_word (w_word),
        .o_word (w_tree_out)
    );

    // ---- control ----
    always_comb begin
        n_state = r_state;
        n_wait  = r_wait;
        n_count = r_count;
        n_hit   = r_hit;
        n_ovf   = r_ovf;
        case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    n_state = ST_SEARCH;
                    n_wait  = '0;
                end
            end
            ST_SEARCH: begin
                if (w_tree_done) begin
                    n_state = ST_APPLY;
                end else begin
                    n_wait = r_wait + 1'b1;
                end
            end
            ST_APPLY: begin
                n_state = ST_SCAN;
                n_wait  = '0;
                n_hit   = (r_kind != KIND_CLEAR) && !r_neg && w_present;
                n_ovf   = (r_kind == KIND_ADD) && !r_neg && !w_present && w_full;
                if (w_ctl.clr) begin
                    n_count = '0;
                end else if (w_ctl.ins) begin
                    n_count = r_count + 1'b1;
                end else if (w_ctl.rem) begin
                    n_count = r_count - 1'b1;
                end
            end
            ST_SCAN: begin
                if (w_tree_done) begin
                    n_state = ST_DONE;
                end else begin
                    n_wait = r_wait + 1'b1;
                end
            end
            ST_DONE: begin
                if (w_out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_wait      <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_wait  <= n_wait;
            r_count <= n_count;
            if (r_state == ST_DONE && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_hit <= n_hit;
        r_ovf <= n_ovf;
        if (w_accept) begin
            r_kind <= i_in_data.kind;
            r_key  <= i_in_data.index[KEY_W-1:0];
            r_neg  <= i_in_data.index[31];
        end
        if (r_state == ST_SCAN && w_tree_done) begin
            r_largest <= w_tree_out;
        end
        if (r_state == ST_DONE && w_out_free) begin
            r_out.hit           <= r_hit;
            r_out.member_count  <= 7'(r_count);
            r_out.largest       <= r_largest;
            r_out.largest_valid <= (r_count != '0);
            r_out.overflow      <= r_ovf;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // ---- checks ----
    `SIS_ASSERT_ALWAYS(a_count_in_range, i_clk, i_rst_n, r_count <= CNT_W'(CAPACITY))
    `SIS_ASSERT_ALWAYS(a_valid_matches_count, i_clk, i_rst_n,
                       $countones(w_valid_vec) == int'(r_count))
    `SIS_ASSERT_NEXT(a_insert_grows, i_clk, i_rst_n, (r_state == ST_APPLY) && w_ctl.ins,
                     r_count == $past(r_count) + 1'b1)
    `SIS_ASSERT_IMPLIES(a_ovf_excludes_hit, i_clk, i_rst_n, r_out_valid,
                        !(r_out.overflow && r_out.hit))
    `SIS_ASSERT_IMPLIES(a_no_double_update, i_clk, i_rst_n, r_state == ST_APPLY,
                        !(w_ctl.ins && w_ctl.rem))

endmodule

// ===== tb/sorted_index_set_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Sorted index set checker
// Keeps its own ascending copy of the set, works out the result of every
// input beat, and compares the output beats in order, field by field.
// ----------------------------------------------------------------------------
module sorted_index_set_checker #(
    parameter int CAPACITY    = sis_pkg::SIS_CAPACITY,
    parameter int MAX_REPORTS = 40
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic              i_in_ready,
    input  sis_pkg::t_sis_in  i_in_data,
    input  logic              i_out_valid,
    input  logic              i_out_ready,
    input  sis_pkg::t_sis_out i_out_data,
    output int                o_fail_count,
    output int                o_pending
);
    import sis_pkg::*;

    logic [KEY_W-1:0] members[$];
    t_sis_out         expected_results[$];
    int               mismatches = 0;
    int               pending_n  = 0;

    assign o_fail_count = mismatches;
    assign o_pending    = pending_n;

    // Apply one operation to the mirrored set and return the result it gives
    function automatic t_sis_out apply_set_op(input t_sis_in op);
        t_sis_out         res;
        logic [KEY_W-1:0] key;
        int               pos;
        bit               present;
        res = '0;
        key = op.index[KEY_W-1:0];
        pos = 0;
        while (pos < members.size() && members[pos] < key) begin
            pos++;
        end
        present = (pos < members.size()) && (members[pos] == key);
        if (op.kind == KIND_CLEAR) begin
            members.delete();
        end else if (!op.index[31]) begin
            res.hit = present;
            if (op.kind == KIND_ADD && !present) begin
                if (members.size() >= CAPACITY) begin
                    res.overflow = 1'b1;
                end else begin
                    members.insert(pos, key);
                end
            end else if (op.kind == KIND_REMOVE && present) begin
                members.delete(pos);
            end
        end
        res.member_count = 7'(members.size());
        if (members.size() > 0) begin
            res.largest       = members[members.size() - 1];
            res.largest_valid = 1'b1;
        end
        return res;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        mismatches++;
        if (mismatches <= MAX_REPORTS) begin
            $display("%0t mismatch %s: got %0h expected %0h", $time, what, got, want);
        end
    endtask

    always @(posedge i_clk) begin : watch
        t_sis_out want;
        if (i_rst_n) begin
            if (i_out_valid && i_out_ready) begin
                if (expected_results.size() == 0) begin
                    report_mismatch("unexpected result beat", i_out_data[31:0], '0);
                end else begin
                    want = expected_results.pop_front();
                    if (i_out_data.hit !== want.hit) begin
                        report_mismatch("hit", 32'(i_out_data.hit), 32'(want.hit));
                    end
                    if (i_out_data.member_count !== want.member_count) begin
                        report_mismatch("member_count", 32'(i_out_data.member_count),
                                        32'(want.member_count));
                    end
                    if (i_out_data.largest !== want.largest) begin
                        report_mismatch("largest", 32'(i_out_data.largest),
                                        32'(want.largest));
                    end
                    if (i_out_data.largest_valid !== want.largest_valid) begin
                        report_mismatch("largest_valid", 32'(i_out_data.largest_valid),
                                        32'(want.largest_valid));
                    end
                    if (i_out_data.overflow !== want.overflow) begin
                        report_mismatch("overflow", 32'(i_out_data.overflow),
                                        32'(want.overflow));
                    end
                end
            end
            if (i_in_valid && i_in_ready) begin
                expected_results.push_back(apply_set_op(i_in_data));
            end
        end
        pending_n <= expected_results.size();
    end

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Sorted index set testbench
// Drives add, remove, contains and clear beats with random gaps and output
// stalls; a directed opening is followed by phases of fill, churn and sparse
// traffic. The checker beside the block predicts and compares every beat.
// ----------------------------------------------------------------------------
module tb;
    import sis_pkg::*;

    localparam int TOTAL_OPS      = 1500;
    localparam int SCRIPT_LEN     = 23;
    localparam int HOLD_CYCLES    = 300;
    localparam int SETTLE_CYCLES  = 40;
    localparam int WATCHDOG_LIMIT = 2000;

    typedef enum {MIX_FILL, MIX_CHURN, MIX_SPARSE} t_mix;

    logic      clk       = 1'b0;
    logic      rst_n     = 1'b0;
    logic      in_valid  = 1'b0;
    logic      in_ready;
    t_sis_in   in_beat   = '0;
    logic      out_valid;
    logic      out_ready = 1'b0;
    t_sis_out  out_beat;

    int        fail_count;
    int        pending;
    int        idle_cycles = 0;
    bit        calm        = 1'b0;
    bit        hold_req    = 1'b0;
    logic [31:0] recent_keys[$];

    logic [1:0]  script_kind [0:SCRIPT_LEN-1] = '{
        KIND_CONTAINS, KIND_REMOVE, KIND_ADD, KIND_ADD, KIND_ADD, KIND_CONTAINS,
        KIND_CONTAINS, KIND_ADD, KIND_ADD, KIND_REMOVE, KIND_CONTAINS, KIND_ADD,
        KIND_ADD, KIND_ADD, KIND_REMOVE, KIND_REMOVE, KIND_REMOVE, KIND_CLEAR,
        KIND_CONTAINS, KIND_ADD, KIND_ADD, KIND_CLEAR, KIND_REMOVE
    };
    logic [31:0] script_index [0:SCRIPT_LEN-1] = '{
        32'h0000_0000, 32'h0000_0007, 32'h0000_0000, 32'h7FFF_FFFF, 32'h0000_0000,
        32'h7FFF_FFFF, 32'h0000_0001, 32'h8000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
        32'h8000_0000, 32'h0000_0064, 32'h0000_0032, 32'h0000_004B, 32'h7FFF_FFFF,
        32'h0000_0032, 32'h0000_0032, 32'hFFFF_FFFF, 32'h0000_0064, 32'h5555_5555,
        32'h2AAA_AAAA, 32'h1234_5678, 32'h0000_0000
    };

    always begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    sorted_index_set_unit DUT (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_beat),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_beat)
    );

    sorted_index_set_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_ready   (in_ready),
        .i_in_data    (in_beat),
        .i_out_valid  (out_valid),
        .i_out_ready  (out_ready),
        .i_out_data   (out_beat),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // Mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 55) begin
            return 0;
        end else if (r < 85) begin
            return $urandom_range(1, 3);
        end else if (r < 96) begin
            return $urandom_range(4, 12);
        end
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [1:0] pick_kind(input t_mix mix);
        int r;
        r = $urandom_range(0, 99);
        case (mix)
            MIX_FILL: begin
                if (r < 75) return KIND_ADD;
                if (r < 85) return KIND_REMOVE;
                if (r < 99) return KIND_CONTAINS;
            end
            MIX_CHURN: begin
                if (r < 40) return KIND_ADD;
                if (r < 75) return KIND_REMOVE;
                if (r < 95) return KIND_CONTAINS;
            end
            default: begin
                if (r < 35) return KIND_ADD;
                if (r < 60) return KIND_REMOVE;
                if (r < 97) return KIND_CONTAINS;
            end
        endcase
        return KIND_CLEAR;
    endfunction

    function automatic logic [31:0] pick_index(input t_mix mix);
        int          r;
        logic [31:0] span;
        r = $urandom_range(0, 99);
        case (mix)
            MIX_FILL:  span = 32'd4095;
            MIX_CHURN: span = 32'd63;
            default:   span = 32'h7FFF_FFFF;
        endcase
        if (r < 30 && recent_keys.size() > 0) begin
            return recent_keys[$urandom_range(0, recent_keys.size() - 1)];
        end else if (r < 65) begin
            return $urandom_range(0, span);
        end else if (r < 75) begin
            return 32'h7FFF_FFFF - $urandom_range(0, 15);
        end
        // full 32-bit range, half of it negative
        return $urandom();
    endfunction

    task automatic send_op(input logic [1:0] kind, input logic [31:0] index);
        t_sis_in beat;
        int      gap;
        beat.kind  = kind;
        beat.index = index;
        in_valid <= 1'b1;
        in_beat  <= beat;
        @(posedge clk);
        while (!in_ready) begin
            @(posedge clk);
        end
        gap = pick_gap();
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        if (kind == KIND_ADD && !index[31]) begin
            recent_keys.push_back(index);
            if (recent_keys.size() > 48) begin
                void'(recent_keys.pop_front());
            end
        end
    endtask

    // Hold the input idle until every result has come back
    task automatic wait_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        wait (pending == 0);
        @(posedge clk);
    endtask

    // Receiver: random stalls, calm stretches, and one long hold-off on request
    initial begin : receiver
        int stall;
        stall = 0;
        forever begin
            @(posedge clk);
            if (hold_req) begin
                hold_req = 1'b0;
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(posedge clk);
            end else if (stall > 0 && !calm) begin
                out_ready <= 1'b0;
                stall--;
            end else begin
                out_ready <= 1'b1;
                stall = 0;
                if (!calm && $urandom_range(0, 3) == 0) begin
                    stall = pick_gap();
                end
            end
        end
    end

    always @(posedge clk) begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin : stimulus
        t_mix mix;
        int   phase;
        int   phase_len;
        int   sent;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < SCRIPT_LEN; i++) begin
            send_op(script_kind[i], script_index[i]);
        end

        sent  = SCRIPT_LEN;
        phase = 0;
        while (sent < TOTAL_OPS) begin
            mix  = (phase == 0) ? MIX_FILL : t_mix'($urandom_range(0, 2));
            calm = (phase == 0) || ($urandom_range(0, 3) == 0);
            // first phase: back-to-back beats against a stalled receiver
            if (phase == 0) begin
                hold_req = 1'b1;
            end
            phase_len = (mix == MIX_FILL) ? $urandom_range(120, 200)
                                          : $urandom_range(40, 120);
            if (phase_len > TOTAL_OPS - sent) begin
                phase_len = TOTAL_OPS - sent;
            end
            repeat (phase_len) begin
                send_op(pick_kind(mix), pick_index(mix));
                sent++;
            end
            if (phase == 1 || $urandom_range(0, 3) == 0) begin
                wait_drained();
            end
            phase++;
        end

        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (fail_count == 0 && pending == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/sis_pkg.sv
rtl/sis_cell.sv
rtl/sis_or_tree.sv
rtl/sorted_index_set_unit.sv
tb/sorted_index_set_checker.sv
tb/tb.sv
